// ===== hw/rtl/rotation_matrix_to_quaternion_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the rotation matrix to quaternion core
// Clocked on aclk; the reset-qualified form is disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH
`ifndef SYNTH
`define RMQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define RMQ_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define RMQ_ASSERT(label, prop, msg)
`define RMQ_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== hw/rtl/rmq_pkg.sv =====
// ---------------------------------------------------------------------------
// rmq_pkg
// Widths, constants and types shared by the quaternion conversion pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package rmq_pkg;

    localparam int DATA_W    = 16;
    localparam int FRAC_W    = 14;
    localparam int CFG_W     = DATA_W - 1;
    localparam int SUM_W     = DATA_W + 2;          // 1 +/- three entries, signed
    localparam int S_W       = DATA_W + 1;          // clamped diagonal sum, unsigned
    localparam int OFF_W     = DATA_W + 1;          // sum/difference of two entries
    localparam int ROOT_W    = (S_W + FRAC_W + 1) / 2;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 3;
    localparam int NUM_W     = S_W + 1;
    localparam int DEN_W     = ROOT_W + 1;
    localparam int QUO_W     = FRAC_W + 1;
    localparam int DIVD_W    = DEN_W + QUO_W;
    localparam int SQ_LAT    = ROOT_W;
    localparam int DIV_LAT   = QUO_W + 1;
    localparam int PIPE_LAT  = 1 + SQ_LAT + 1 + DIV_LAT;

    localparam logic [CFG_W-1:0] ONE_FX     = CFG_W'(1 << FRAC_W);
    localparam logic [CFG_W-1:0] FLOOR_RST  = CFG_W'(((1 << FRAC_W) + 5) / 10);

    typedef logic [1:0] lane_t;
    localparam lane_t LANE_R = 2'd0;
    localparam lane_t LANE_I = 2'd1;
    localparam lane_t LANE_J = 2'd2;
    localparam lane_t LANE_K = 2'd3;

    typedef struct packed {
        logic [3:0][S_W-1:0]          s;      // clamped diagonal sums
        logic signed [OFF_W-1:0]      a;      // m21 - m12
        logic signed [OFF_W-1:0]      b;      // m02 - m20
        logic signed [OFF_W-1:0]      c;      // m10 - m01
        logic signed [OFF_W-1:0]      d;      // m10 + m01
        logic signed [OFF_W-1:0]      e;      // m02 + m20
        logic signed [OFF_W-1:0]      f;      // m12 + m21
    } side_t;

    typedef struct packed {
        logic                 ovf;
        logic                 neg;
        logic [QUO_W-1:0]     quo;
    } quo_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rmq_sqrt.sv =====
// ---------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one result bit per register stage.
// ---------------------------------------------------------------------------
`default_nettype none
module rmq_sqrt (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [rmq_pkg::RAD_W-1:0]     rad,
    output logic      [rmq_pkg::ROOT_W-1:0]    root
);
    localparam int NST = rmq_pkg::SQ_LAT;
    localparam int RW  = rmq_pkg::RAD_W;
    localparam int MW  = rmq_pkg::REM_W;
    localparam int QW  = rmq_pkg::ROOT_W;

    logic [RW-1:0] rad_reg  [NST];
    logic [MW-1:0] rem_reg  [NST];
    logic [QW-1:0] root_reg [NST];

    genvar k;
    generate
        for (k = 0; k < NST; k++) begin : g_stage
            logic [RW-1:0] rad_in;
            logic [MW-1:0] rem_in;
            logic [QW-1:0] root_in;
            logic [MW-1:0] rem_sh;
            logic [MW-1:0] trial;
            logic [RW-1:0] rad_next;
            logic [MW-1:0] rem_next;
            logic [QW-1:0] root_next;

            if (k == 0) begin : g_first
                assign rad_in  = rad;
                assign rem_in  = '0;
                assign root_in = '0;
            end else begin : g_rest
                assign rad_in  = rad_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
            end

            always_comb begin
                rem_sh   = {rem_in[MW-3:0], rad_in[RW-1 -: 2]};
                trial    = MW'({root_in, 2'b01});
                rad_next = {rad_in[RW-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_in[QW-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_in[QW-2:0], 1'b0};
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[k]  <= rad_next;
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                end
            end
        end
    endgenerate

    assign root = root_reg[NST-1];

endmodule
`default_nettype wire

// ===== hw/rtl/rmq_div.sv =====
// ---------------------------------------------------------------------------
// rmq_div
// Pipelined signed fixed-point divide, rounded to nearest, with an overflow
// flag once the quotient magnitude leaves the quotient width.
// ---------------------------------------------------------------------------
`default_nettype none
module rmq_div (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic signed [rmq_pkg::NUM_W-1:0]    num,
    input  wire logic        [rmq_pkg::DEN_W-1:0]    den,
    output rmq_pkg::quo_t                            res
);
    localparam int NST = rmq_pkg::QUO_W;
    localparam int XW  = rmq_pkg::DIVD_W;
    localparam int DW  = rmq_pkg::DEN_W;
    localparam int QW  = rmq_pkg::QUO_W;

    logic [XW-1:0] part_reg [NST+1];
    logic [DW-1:0] den_reg  [NST+1];
    logic [QW-1:0] quo_reg  [NST+1];
    logic          ovf_reg  [NST+1];
    logic          neg_reg  [NST+1];

    logic                       neg_c;
    logic [rmq_pkg::NUM_W-1:0]  mag_c;
    logic [XW-1:0]              dvd_c;

    // prepare: magnitude, rounding bias and overflow check
    always_comb begin
        neg_c = num[rmq_pkg::NUM_W-1];
        mag_c = neg_c ? (rmq_pkg::NUM_W)'(-num) : (rmq_pkg::NUM_W)'(num);
        dvd_c = (XW'(mag_c) << rmq_pkg::FRAC_W) + XW'(den >> 1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            part_reg[0] <= dvd_c;
            den_reg[0]  <= den;
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= dvd_c >= (XW'(den) << QW);
            neg_reg[0]  <= neg_c;
        end
    end

    genvar k;
    generate
        for (k = 0; k < NST; k++) begin : g_stage
            logic [XW-1:0] sub;
            logic          fit;
            assign sub = XW'(den_reg[k]) << (QW - 1 - k);
            assign fit = part_reg[k] >= sub;

            always_ff @(posedge aclk) begin
                if (en) begin
                    part_reg[k+1] <= fit ? part_reg[k] - sub : part_reg[k];
                    quo_reg[k+1]  <= quo_reg[k] | (QW'(fit) << (QW - 1 - k));
                    den_reg[k+1]  <= den_reg[k];
                    ovf_reg[k+1]  <= ovf_reg[k];
                    neg_reg[k+1]  <= neg_reg[k];
                end
            end
        end
    endgenerate

    assign res.ovf = ovf_reg[NST];
    assign res.neg = neg_reg[NST];
    assign res.quo = quo_reg[NST];

endmodule
`default_nettype wire

// ===== hw/rtl/rotation_matrix_to_quaternion_core.sv =====
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Converts a 3x3 Q1.14 rotation matrix to a standardized unit quaternion.
// ---------------------------------------------------------------------------
// Usage:
//   s_* channel takes one matrix per request, nine 16-bit entries in tdata.
//   m_* channel gives the quaternion (i, j, k, real) for each matrix.
//   cfg_* channel writes denominator_floor; it is always ready. Write it only
//   while no matrix is in flight.
// Pipeline: a request passes the sum register, the 16-stage square root,
//   the select register, the 16-stage divider and the output register in
//   series.
// Throughput: one matrix per cycle while s_tready is high; every stage is a register stage.
// Reset: aresetn low empties the pipeline and the output stage, and loads
//   the floor with 0.1 in Q1.14.
// Stall: when m_tready is low the result holds, one more result lands in a
//   skid register, and s_tready drops only while that skid register is full.
// ---------------------------------------------------------------------------
`default_nettype none
module rotation_matrix_to_quaternion_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [14:0]   cfg_data,      // denominator_floor
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // m_row0_col0, m_row0_col1, m_row0_col2, m_row1_col0, m_row1_col1,
    // m_row1_col2, m_row2_col0, m_row2_col1, m_row2_col2 (16 bits each)
    input  wire logic [143:0]  s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // quat_i [15:0], quat_j [31:16], quat_k [47:32], quat_real [62:48], zero [63]
    output logic [63:0]        m_tdata
);
`include "rotation_matrix_to_quaternion_core_assert.svh"

    localparam int DW   = rmq_pkg::DATA_W;
    localparam int SW   = rmq_pkg::SUM_W;
    localparam int S_W  = rmq_pkg::S_W;
    localparam int OW   = rmq_pkg::OFF_W;
    localparam int QW   = rmq_pkg::ROOT_W;
    localparam int NW   = rmq_pkg::NUM_W;
    localparam int CW   = rmq_pkg::CFG_W;
    localparam int UW   = rmq_pkg::QUO_W;
    localparam int PL   = rmq_pkg::PIPE_LAT;
    localparam int SQL  = rmq_pkg::SQ_LAT;

    // configuration
    logic [CW-1:0] floor_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= rmq_pkg::FLOOR_RST;
        end else if (cfg_valid) begin
            floor_reg <= cfg_data;
        end
    end

    // pipeline control
    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;
    logic vld_reg [PL];

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PL; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < PL; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // stage 1: diagonal sums and off-diagonal pairs
    logic signed [DW-1:0] m [9];
    logic signed [SW-1:0] sum_c [4];
    rmq_pkg::side_t       side_c;
    rmq_pkg::side_t       side_reg [SQL+1];

    always_comb begin
        for (int i = 0; i < 9; i++) m[i] = s_tdata[i*DW +: DW];
        sum_c[0] = SW'(rmq_pkg::ONE_FX) + SW'(m[0]) + SW'(m[4]) + SW'(m[8]);
        sum_c[1] = SW'(rmq_pkg::ONE_FX) + SW'(m[0]) - SW'(m[4]) - SW'(m[8]);
        sum_c[2] = SW'(rmq_pkg::ONE_FX) - SW'(m[0]) + SW'(m[4]) - SW'(m[8]);
        sum_c[3] = SW'(rmq_pkg::ONE_FX) - SW'(m[0]) - SW'(m[4]) + SW'(m[8]);
        for (int i = 0; i < 4; i++) begin
            side_c.s[i] = sum_c[i][SW-1] ? '0 : sum_c[i][S_W-1:0];
        end
        side_c.a = OW'(m[7]) - OW'(m[5]);
        side_c.b = OW'(m[2]) - OW'(m[6]);
        side_c.c = OW'(m[3]) - OW'(m[1]);
        side_c.d = OW'(m[3]) + OW'(m[1]);
        side_c.e = OW'(m[2]) + OW'(m[6]);
        side_c.f = OW'(m[5]) + OW'(m[7]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_c;
            for (int i = 1; i <= SQL; i++) side_reg[i] <= side_reg[i-1];
        end
    end

    // square roots of the four sums
    logic [QW-1:0] root [4];
    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_sqrt
            rmq_sqrt u_sqrt (
                .aclk (aclk),
                .en   (en),
                .rad  (rmq_pkg::RAD_W'(side_reg[0].s[g]) << rmq_pkg::FRAC_W),
                .root (root[g])
            );
        end
    endgenerate

    // select: largest root, first on ties, and its candidate row
    rmq_pkg::side_t       sd;
    logic [1:0]           best_c;
    logic [QW-1:0]        bq_c;
    logic [CW-1:0]        fl_c;
    logic [QW-1:0]        rt_c;
    logic signed [NW-1:0] num_c [4];
    logic signed [NW-1:0] num_reg [4];
    logic [rmq_pkg::DEN_W-1:0] den_reg;

    always_comb begin
        sd     = side_reg[SQL];
        best_c = 2'd0;
        bq_c   = root[0];
        for (int i = 1; i < 4; i++) begin
            if (root[i] > bq_c) begin
                bq_c   = root[i];
                best_c = 2'(i);
            end
        end
        fl_c = (floor_reg == '0) ? CW'(1) : floor_reg;
        rt_c = (bq_c > QW'(fl_c)) ? bq_c : QW'(fl_c);
        case (best_c)
            2'd0: begin
                num_c[rmq_pkg::LANE_R] = NW'(sd.s[0]);
                num_c[rmq_pkg::LANE_I] = NW'(sd.a);
                num_c[rmq_pkg::LANE_J] = NW'(sd.b);
                num_c[rmq_pkg::LANE_K] = NW'(sd.c);
            end
            2'd1: begin
                num_c[rmq_pkg::LANE_R] = NW'(sd.a);
                num_c[rmq_pkg::LANE_I] = NW'(sd.s[1]);
                num_c[rmq_pkg::LANE_J] = NW'(sd.d);
                num_c[rmq_pkg::LANE_K] = NW'(sd.e);
            end
            2'd2: begin
                num_c[rmq_pkg::LANE_R] = NW'(sd.b);
                num_c[rmq_pkg::LANE_I] = NW'(sd.d);
                num_c[rmq_pkg::LANE_J] = NW'(sd.s[2]);
                num_c[rmq_pkg::LANE_K] = NW'(sd.f);
            end
            default: begin
                num_c[rmq_pkg::LANE_R] = NW'(sd.c);
                num_c[rmq_pkg::LANE_I] = NW'(sd.e);
                num_c[rmq_pkg::LANE_J] = NW'(sd.f);
                num_c[rmq_pkg::LANE_K] = NW'(sd.s[3]);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) num_reg[i] <= num_c[i];
            den_reg <= {rt_c, 1'b0};
        end
    end

    // divide each component by twice the root, raised to at least the floor
    rmq_pkg::quo_t quo [4];
    generate
        for (g = 0; g < 4; g++) begin : g_div
            rmq_div u_div (
                .aclk (aclk),
                .en   (en),
                .num  (num_reg[g]),
                .den  (den_reg),
                .res  (quo[g])
            );
        end
    endgenerate

    // standardize sign and saturate
    logic [UW-1:0]        mag  [4];
    logic                 zero [4];
    logic                 flip;
    logic [DW-1:0]        comp [3];
    logic [63:0]          res_c;
    logic                 push;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            zero[i] = !quo[i].ovf && (quo[i].quo == '0);
            mag[i]  = (quo[i].ovf || quo[i].quo > rmq_pkg::ONE_FX) ? rmq_pkg::ONE_FX
                                                                   : quo[i].quo;
        end
        flip = quo[rmq_pkg::LANE_R].neg && !zero[rmq_pkg::LANE_R];
        for (int i = 0; i < 3; i++) begin
            comp[i] = ((quo[i+1].neg ^ flip) && !zero[i+1]) ? DW'(-DW'(mag[i+1]))
                                                            : DW'(mag[i+1]);
        end
        res_c = {1'b0, mag[rmq_pkg::LANE_R], comp[2], comp[1], comp[0]};
        push  = en && vld_reg[PL-1];
    end

    // output register with one skid entry
    logic [63:0] out_reg;
    logic [63:0] skid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : res_c;
        end else if (push) begin
            skid_reg <= res_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    `RMQ_ASSERT(a_skid_needs_out, skid_valid_reg |-> out_valid_reg, "skid full with output empty")
    `RMQ_ASSERT(a_real_range, out_valid_reg |-> (out_reg[62:48] <= rmq_pkg::ONE_FX), "real too big")
    `RMQ_ASSERT(a_no_push_when_full, skid_valid_reg |-> !push, "result pushed into a full skid")
    `RMQ_ASSERT_RST(a_reset_empty, $past(!aresetn) |-> (!out_valid_reg && !skid_valid_reg), "not empty")

endmodule
`default_nettype wire

// ===== sim/tb_rotation_matrix_to_quaternion_core.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for rotation_matrix_to_quaternion_core
// Streams directed and random matrices through the core, predicts each
// quaternion in the bench and compares it field by field with the output.
// Both sides pause at random outside the burst phases. The floor register is swept between phases.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_rotation_matrix_to_quaternion_core;

    localparam int ONE       = 1 << rmq_pkg::FRAC_W;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = rmq_pkg::PIPE_LAT + 20;

    typedef struct {
        logic signed [15:0] qi;
        logic signed [15:0] qj;
        logic signed [15:0] qk;
        logic [14:0]        qr;
    } quat_t;

    logic          aclk;
    logic          aresetn;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [14:0]   cfg_data;
    logic          s_tvalid;
    logic          s_tready;
    logic [143:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [63:0]   m_tdata;

    logic [143:0]  matrix_q[$];
    quat_t         quat_exp_q[$];
    logic [14:0]   floor_val;
    int            n_err;
    int            wdog;
    bit            timed_out;

    rotation_matrix_to_quaternion_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // round to nearest, ties away from zero
    function automatic longint round_div(longint n, longint d);
        longint mag;
        longint qv;
        mag = (n < 0) ? -n : n;
        qv = ((mag << rmq_pkg::FRAC_W) + (d >> 1)) / d;
        return (n < 0) ? -qv : qv;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic quat_t matrix_to_quat(logic [143:0] mat, logic [14:0] flr);
        longint m[9];
        longint s[4];
        longint unsigned q[4];
        longint rows[4][4];
        longint res[4];
        longint den;
        longint fl;
        int win;
        quat_t o;
        for (int n = 0; n < 9; n++) m[n] = longint'($signed(mat[16*n +: 16]));
        s[0] = ONE + m[0] + m[4] + m[8];
        s[1] = ONE + m[0] - m[4] - m[8];
        s[2] = ONE - m[0] + m[4] - m[8];
        s[3] = ONE - m[0] - m[4] + m[8];
        for (int n = 0; n < 4; n++) begin
            if (s[n] < 0) s[n] = 0;
            q[n] = (s[n] > 0) ? int_sqrt(longint'(s[n]) << rmq_pkg::FRAC_W) : 0;
        end
        win = 0;
        for (int n = 1; n < 4; n++) if (q[n] > q[win]) win = n;
        rows[0] = '{s[0], m[7] - m[5], m[2] - m[6], m[3] - m[1]};
        rows[1] = '{m[7] - m[5], s[1], m[3] + m[1], m[2] + m[6]};
        rows[2] = '{m[2] - m[6], m[3] + m[1], s[2], m[5] + m[7]};
        rows[3] = '{m[3] - m[1], m[6] + m[2], m[7] + m[5], s[3]};
        fl = (flr == 0) ? 1 : longint'(flr);
        den = 2 * ((longint'(q[win]) > fl) ? longint'(q[win]) : fl);
        for (int n = 0; n < 4; n++) res[n] = round_div(rows[win][(n + 1) % 4], den);
        if (res[3] < 0) for (int n = 0; n < 4; n++) res[n] = -res[n];
        o.qi = 16'(clip(res[0], -ONE, ONE));
        o.qj = 16'(clip(res[1], -ONE, ONE));
        o.qk = 16'(clip(res[2], -ONE, ONE));
        o.qr = 15'(clip(res[3], 0, ONE));
        return o;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // append one matrix to the pending list
    function automatic void add_matrix(logic [143:0] v);
        matrix_q = {matrix_q, v};
    endfunction

    // driver
    int  s_gap;
    bit  s_burst;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                quat_exp_q = {quat_exp_q, matrix_to_quat(s_tdata, floor_val)};
                s_gap = s_burst ? 0 : pick_gap();
            end
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_tvalid <= 1'b0;
                end else if (matrix_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= matrix_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int  m_gap;
    bit  m_burst;
    always @(posedge aclk) begin
        quat_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (quat_exp_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("Unexpected result %h", m_tdata);
                end else begin
                    e = quat_exp_q.pop_front();
                    if (m_tdata[15:0] !== e.qi || m_tdata[31:16] !== e.qj ||
                        m_tdata[47:32] !== e.qk || m_tdata[62:48] !== e.qr ||
                        m_tdata[63] !== 1'b0) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("Mismatch: exp i=%0d j=%0d k=%0d r=%0d got %h",
                                     e.qi, e.qj, e.qk, e.qr, m_tdata);
                    end
                end
            end
            if (m_gap > 0) begin
                m_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                m_gap = m_burst ? 0 : ((pick_gap() > 0) ? pick_gap() : 0);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (matrix_q.size() == 0 && quat_exp_q.size() == 0 && !s_tvalid && !cfg_valid)) begin
            wdog <= 0;
        end else begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_MAX && !timed_out) begin
                timed_out = 1'b1;
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic logic [143:0] pack_matrix(int e[9]);
        logic [143:0] v;
        for (int n = 0; n < 9; n++) v[16*n +: 16] = 16'(e[n]);
        return v;
    endfunction

    function automatic logic [143:0] random_matrix();
        int e[9];
        int mode;
        int sh;
        mode = $urandom_range(9);
        for (int n = 0; n < 9; n++) begin
            if (mode < 6)
                e[n] = $signed(16'($urandom_range(2 * ONE))) - ONE;
            else
                e[n] = $signed(16'($urandom));
        end
        // bias one diagonal entry, or all three for the real row, so every row wins sometimes
        if (mode < 6) begin
            sh = $urandom_range(3);
            e[0] = (sh == 1) ? ONE - $urandom_range(800) : e[0] / 2;
            e[4] = (sh == 2) ? ONE - $urandom_range(800) : e[4] / 2;
            e[8] = (sh == 3) ? ONE - $urandom_range(800) : e[8] / 2;
            if (sh == 0) begin
                e[0] = ONE - $urandom_range(800);
                e[4] = ONE - $urandom_range(800);
                e[8] = ONE - $urandom_range(800);
            end
        end
        return pack_matrix(e);
    endfunction

    task automatic write_floor(logic [14:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        floor_val = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (matrix_q.size() > 0 || quat_exp_q.size() > 0 || s_tvalid) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    logic [14:0] floors[5] = '{15'd1638, 15'd1, 15'd0, 15'd16384, 15'd32767};

    initial begin
        int e[9];
        n_err = 0;
        timed_out = 1'b0;
        floor_val = rmq_pkg::FLOOR_RST;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        s_burst = 1'b0;
        m_burst = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // identity, the three half-turns, zero matrix, two quarter-turns about z, extremes
        e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};   add_matrix(pack_matrix(e));
        e = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}; add_matrix(pack_matrix(e));
        e = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}; add_matrix(pack_matrix(e));
        e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}; add_matrix(pack_matrix(e));
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};         add_matrix(pack_matrix(e));
        e = '{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE};  add_matrix(pack_matrix(e));
        e = '{0, ONE, 0, -ONE, 0, 0, 0, 0, ONE};  add_matrix(pack_matrix(e));
        add_matrix({9{16'h8000}});
        add_matrix({9{16'h7fff}});
        add_matrix({9{16'hffff}});
        add_matrix({9{16'h5555}});
        add_matrix({9{16'haaaa}});
        // real-row sum negative: its root clamps to zero, the other three sums tie
        e = '{-32768, 32767, -32768, -32768, -32768, 32767, 32767, -32768, -32768};
        add_matrix(pack_matrix(e));
        // equal roots: first row wins ties
        e = '{0, 100, -100, 200, 0, 300, -300, 400, 0};
        add_matrix(pack_matrix(e));
        // real part exactly zero
        e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}; add_matrix(pack_matrix(e));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_floor((ph < 5) ? floors[ph] : 15'($urandom_range(16384, 1)));
            s_burst = (ph == 2);
            m_burst = (ph == 2) || (ph == 4);
            for (int n = 0; n < 180; n++) add_matrix(random_matrix());
            if (ph == 3) for (int n = 0; n < 15; n++) add_matrix(144'($urandom));
            drain();
        end

        if (n_err == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
